### rtl/core/alfp_pkg.sv
// ----------------------------------------------------------------------------
// alfp_pkg
// Shared types and constants of the length-framed packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

package alfp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 7;
  localparam int unsigned KindW = 3;

  localparam logic [ByteW-1:0] CH_START  = 8'h3C;
  localparam logic [ByteW-1:0] CH_SEP    = 8'h24;
  localparam logic [ByteW-1:0] CH_END    = 8'h3E;
  localparam logic [ByteW-1:0] CH_ZERO   = 8'h30;
  localparam logic [ByteW-1:0] CH_NINE   = 8'h39;
  localparam logic [ByteW-1:0] CH_REQ_HI = 8'h34;
  localparam logic [ByteW-1:0] TYPE_OFFSET = 8'd5;
  localparam logic [LenW-1:0]  MIN_LEN   = 7'd7;
  localparam logic [LenW-1:0]  HDR_LEN   = 7'd4;

  localparam logic [ByteW-1:0] REQ_TYPE_RESET = CH_REQ_HI;

  typedef enum logic [KindW-1:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_OK       = 3'd1,
    KIND_MISMATCH = 3'd2,
    KIND_NO_END   = 3'd3,
    KIND_BAD_HDR  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_DIG1 = 3'd1,
    PH_DIG2 = 3'd2,
    PH_LSEP = 3'd3,
    PH_TYPE = 3'd4,
    PH_TSEP = 3'd5,
    PH_REST = 3'd6
  } phase_t;

  typedef struct packed {
    kind_t             kind;
    logic [ByteW-1:0]  data_byte;
    logic [LenW-1:0]   frame_length;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/alfp_in_reg.sv
// ----------------------------------------------------------------------------
// alfp_in_reg
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module alfp_in_reg (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [alfp_pkg::ByteW-1:0] in_tdata,
  input  wire logic                      pop,
  output logic                           hold_valid,
  output logic [alfp_pkg::ByteW-1:0]     hold_byte
);

  logic                       valid_r, valid_nxt;
  logic [alfp_pkg::ByteW-1:0] byte_r;

  assign in_tready  = !valid_r || pop;
  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

endmodule

`default_nettype wire

### rtl/core/alfp_parser.sv
// ----------------------------------------------------------------------------
// alfp_parser
// Frame state machine: one byte per step, at most one result per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module alfp_parser (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [alfp_pkg::ByteW-1:0] cfg_wr_data,
  input  wire logic                       step,
  input  wire logic [alfp_pkg::ByteW-1:0] rx_byte,
  output logic                            res_valid,
  output alfp_pkg::result_t               res
);

  alfp_pkg::phase_t           phase_r, phase_nxt;
  logic [alfp_pkg::LenW-1:0]  len_r, len_nxt;
  logic [alfp_pkg::LenW-1:0]  body_r, body_nxt;
  logic                       matched_r, matched_nxt;
  logic                       sep_ok_r, sep_ok_nxt;
  logic                       end_r, end_nxt;
  logic [alfp_pkg::ByteW-1:0] type_r, type_nxt;
  logic [alfp_pkg::ByteW-1:0] req_r;

  logic                       is_digit;
  logic                       req_ok;
  logic [alfp_pkg::LenW-1:0]  len_acc;
  logic [alfp_pkg::LenW-1:0]  body_dec;

  assign is_digit = (rx_byte >= alfp_pkg::CH_ZERO) && (rx_byte <= alfp_pkg::CH_NINE);
  assign req_ok   = (req_r >= alfp_pkg::CH_ZERO) && (req_r <= alfp_pkg::CH_REQ_HI);
  // len * 10 + digit, wrapped to the field width
  assign len_acc  = {len_r[alfp_pkg::LenW-4:0], 3'b000} + {len_r[alfp_pkg::LenW-2:0], 1'b0}
                    + {3'b000, rx_byte[3:0]};
  assign body_dec = body_r - 7'd1;

  always_comb begin
    phase_nxt   = phase_r;
    len_nxt     = len_r;
    body_nxt    = body_r;
    matched_nxt = matched_r;
    sep_ok_nxt  = sep_ok_r;
    end_nxt     = end_r;
    type_nxt    = type_r;
    res_valid   = 1'b0;
    res         = '{kind: alfp_pkg::KIND_PAYLOAD, data_byte: '0, frame_length: '0};
    if (step) begin
      case (phase_r)
        alfp_pkg::PH_IDLE: begin
          if (rx_byte == alfp_pkg::CH_START) begin
            phase_nxt   = alfp_pkg::PH_DIG1;
            len_nxt     = '0;
            body_nxt    = '0;
            matched_nxt = 1'b0;
            sep_ok_nxt  = 1'b1;
            end_nxt     = 1'b0;
            type_nxt    = '0;
          end
        end
        alfp_pkg::PH_DIG1, alfp_pkg::PH_DIG2: begin
          if (is_digit && sep_ok_r) begin
            len_nxt = len_acc;
          end else begin
            sep_ok_nxt = 1'b0;
          end
          phase_nxt = (phase_r == alfp_pkg::PH_DIG1) ? alfp_pkg::PH_DIG2 : alfp_pkg::PH_LSEP;
        end
        alfp_pkg::PH_LSEP: begin
          if (!sep_ok_r) begin
            len_nxt   = '0;
            phase_nxt = alfp_pkg::PH_IDLE;
            res_valid = 1'b1;
            res.kind  = alfp_pkg::KIND_BAD_HDR;
          end else if (rx_byte != alfp_pkg::CH_SEP || len_r < alfp_pkg::MIN_LEN) begin
            phase_nxt        = alfp_pkg::PH_IDLE;
            res_valid        = 1'b1;
            res.kind         = alfp_pkg::KIND_BAD_HDR;
            res.frame_length = len_r;
          end else begin
            body_nxt   = len_r - alfp_pkg::HDR_LEN;
            sep_ok_nxt = 1'b0;
            phase_nxt  = alfp_pkg::PH_TYPE;
          end
        end
        alfp_pkg::PH_TYPE: begin
          type_nxt    = rx_byte;
          matched_nxt = req_ok && (rx_byte == req_r + alfp_pkg::TYPE_OFFSET);
          body_nxt    = body_dec;
          phase_nxt   = alfp_pkg::PH_TSEP;
        end
        alfp_pkg::PH_TSEP: begin
          sep_ok_nxt = (rx_byte == alfp_pkg::CH_SEP);
          body_nxt   = body_dec;
          phase_nxt  = alfp_pkg::PH_REST;
        end
        alfp_pkg::PH_REST: begin
          body_nxt = body_dec;
          if (body_dec == '0) begin
            phase_nxt        = alfp_pkg::PH_IDLE;
            res_valid        = 1'b1;
            res.data_byte    = type_r;
            res.frame_length = len_r;
            if (!sep_ok_r) begin
              res.kind = alfp_pkg::KIND_BAD_HDR;
            end else if (!matched_r) begin
              res.kind = alfp_pkg::KIND_MISMATCH;
            end else if (end_r || rx_byte == alfp_pkg::CH_END) begin
              res.kind = alfp_pkg::KIND_OK;
            end else begin
              res.kind = alfp_pkg::KIND_NO_END;
            end
          end else if (!end_r) begin
            if (rx_byte == alfp_pkg::CH_END) begin
              end_nxt = 1'b1;
            end else if (matched_r && sep_ok_r) begin
              res_valid        = 1'b1;
              res.data_byte    = rx_byte;
              res.frame_length = len_r;
            end
          end
        end
        default: begin
          phase_nxt = alfp_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= alfp_pkg::PH_IDLE;
      len_r     <= '0;
      body_r    <= '0;
      matched_r <= 1'b0;
      sep_ok_r  <= 1'b0;
      end_r     <= 1'b0;
      type_r    <= '0;
      req_r     <= alfp_pkg::REQ_TYPE_RESET;
    end else begin
      phase_r   <= phase_nxt;
      len_r     <= len_nxt;
      body_r    <= body_nxt;
      matched_r <= matched_nxt;
      sep_ok_r  <= sep_ok_nxt;
      end_r     <= end_nxt;
      type_r    <= type_nxt;
      if (cfg_wr_en) begin
        req_r <= cfg_wr_data;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/alfp_out_reg.sv
// ----------------------------------------------------------------------------
// alfp_out_reg
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module alfp_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  alfp_pkg::result_t      res,
  output logic                   free,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output alfp_pkg::result_t      out_res
);

  logic              valid_r, valid_nxt;
  alfp_pkg::result_t res_r;

  assign free       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_res    = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ascii_length_framed_packet_parser.sv
// ----------------------------------------------------------------------------
// ascii_length_framed_packet_parser
// Parses '<' D D '$' TYPE '$' payload '>' frames from a byte stream.
// ----------------------------------------------------------------------------
// One received byte per cycle, sustained while the result side keeps up. A
// byte goes from the input register through the frame state machine into the
// result register; a result held by a stalled sink holds the next byte in the
// input register. Payload bytes come out as kind 0, and each frame closes
// with one status: 1 ok, 2 type mismatch, 3 no end mark, 4 bad header (bad
// digit, bad separator or length below 7). The requested type is written
// through cfg_wr_en / cfg_wr_data; the user must do so only while the block
// is idle, and the block itself does not enforce this.
`default_nettype none

module ascii_length_framed_packet_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,   // requested_type
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,      // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,     // [7:0] data_byte, [14:8] frame_length, [15] zero
  output logic [2:0]       out_tuser      // [2:0] kind
);

  logic              hold_valid;
  logic [7:0]        hold_byte;
  logic              out_free;
  logic              step;
  logic              res_valid;
  alfp_pkg::result_t res;
  alfp_pkg::result_t out_res;

  assign step = hold_valid && out_free;

  alfp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .pop        (step),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  alfp_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .rx_byte     (hold_byte),
    .res_valid   (res_valid),
    .res         (res)
  );

  alfp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step && res_valid),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {1'b0, out_res.frame_length, out_res.data_byte};
  assign out_tuser = out_res.kind;

endmodule

`default_nettype wire

### tb/sv/tb_ascii_length_framed_packet_parser.sv
// ----------------------------------------------------------------------------
// tb_ascii_length_framed_packet_parser
// Streams framed and broken byte sequences into the packet parser under
// bursty input and a stalling result side. A cycle-free model of the frame
// state machine predicts every payload byte and closing status, and each
// result is compared field by field in order. The requested type is changed
// between traffic phases, its extremes and out-of-range values included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ascii_length_framed_packet_parser;
  import alfp_pkg::*;

  localparam int PhaseBytes = 220;

  class frame_result_tracker;
    logic [7:0] req_type;
    phase_t     ph;
    logic [6:0] len_acc;
    logic [6:0] body_left;
    bit         type_ok;
    bit         sep_ok;
    bit         end_seen;
    logic [7:0] type_byte;
    result_t    awaited[$];
    int unsigned n_bytes;
    int unsigned n_frames;
    int unsigned n_checked;
    int unsigned n_errors;
    int unsigned n_kind[5];

    function new();
      req_type  = REQ_TYPE_RESET;
      ph        = PH_IDLE;
      len_acc   = '0;
      body_left = '0;
      type_ok   = 1'b0;
      sep_ok    = 1'b0;
      end_seen  = 1'b0;
      type_byte = '0;
    endfunction

    function void flag(string msg);
      n_errors++;
      if (n_errors <= 10) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
    endfunction

    function void take_byte(logic [7:0] b);
      result_t r;
      bit      emit;
      r    = '0;
      emit = 1'b0;
      n_bytes++;
      case (ph)
        PH_IDLE: begin
          if (b == CH_START) begin
            ph        = PH_DIG1;
            len_acc   = '0;
            body_left = '0;
            type_ok   = 1'b0;
            sep_ok    = 1'b1;
            end_seen  = 1'b0;
            type_byte = '0;
            n_frames++;
          end
        end
        PH_DIG1, PH_DIG2: begin
          if (b >= CH_ZERO && b <= CH_NINE && sep_ok) begin
            len_acc = 7'(len_acc * 10 + (b - CH_ZERO));
          end else begin
            sep_ok = 1'b0;
          end
          ph = (ph == PH_DIG1) ? PH_DIG2 : PH_LSEP;
        end
        PH_LSEP: begin
          emit        = 1'b1;
          r.kind      = KIND_BAD_HDR;
          r.data_byte = '0;
          if (!sep_ok) begin
            len_acc        = '0;
            r.frame_length = '0;
            ph             = PH_IDLE;
          end else if (b != CH_SEP || len_acc < MIN_LEN) begin
            r.frame_length = len_acc;
            ph             = PH_IDLE;
          end else begin
            emit      = 1'b0;
            body_left = len_acc - HDR_LEN;
            sep_ok    = 1'b0;
            ph        = PH_TYPE;
          end
        end
        PH_TYPE: begin
          type_byte = b;
          type_ok   = (req_type >= CH_ZERO) && (req_type <= CH_REQ_HI) &&
                      (b == 8'(req_type + TYPE_OFFSET));
          body_left = body_left - 7'd1;
          ph        = PH_TSEP;
        end
        PH_TSEP: begin
          sep_ok    = (b == CH_SEP);
          body_left = body_left - 7'd1;
          ph        = PH_REST;
        end
        PH_REST: begin
          body_left = body_left - 7'd1;
          if (body_left == 0) begin
            emit           = 1'b1;
            ph             = PH_IDLE;
            r.data_byte    = type_byte;
            r.frame_length = len_acc;
            if (!sep_ok) r.kind = KIND_BAD_HDR;
            else if (!type_ok) r.kind = KIND_MISMATCH;
            else if (end_seen || b == CH_END) r.kind = KIND_OK;
            else r.kind = KIND_NO_END;
          end else if (!end_seen) begin
            if (b == CH_END) begin
              end_seen = 1'b1;
            end else if (type_ok && sep_ok) begin
              emit           = 1'b1;
              r.kind         = KIND_PAYLOAD;
              r.data_byte    = b;
              r.frame_length = len_acc;
            end
          end
        end
        default: ph = PH_IDLE;
      endcase
      if (emit) awaited.push_back(r);
    endfunction

    function void match_result(logic [2:0] k, logic [7:0] d, logic [6:0] l);
      result_t want;
      if (awaited.size() == 0) begin
        flag($sformatf("unexpected result kind %0d data %02h length %0d", k, d, l));
        return;
      end
      want = awaited.pop_front();
      n_checked++;
      n_kind[want.kind]++;
      if (k !== want.kind || d !== want.data_byte || l !== want.frame_length) begin
        flag($sformatf("expected kind %0d data %02h length %0d, got kind %0d data %02h length %0d",
                       want.kind, want.data_byte, want.frame_length, k, d, l));
      end
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = 8'h00;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;

  frame_result_tracker tracker = new();

  int burst_left = 0;
  int stall_mode = 0;
  int stall_span = 0;
  int rx_cycle   = 0;

  ascii_length_framed_packet_parser u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.match_result(out_tuser, out_tdata[7:0], out_tdata[14:8]);
    end
    rx_cycle++;
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(20, 200);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ((rx_cycle % 7) < 4);
    endcase
  end

  task automatic push_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.take_byte(b);
    burst_left--;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // drop valid, drain every awaited result, then give the pipeline time
  task automatic let_block_settle();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_request_type(input logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tracker.req_type = v;
  endtask

  task automatic send_random_frame();
    logic [7:0] fb[$];
    logic [7:0] bad;
    int sel;
    int len;
    int nrest;
    int endpos;
    sel = $urandom_range(0, 99);
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(21, 99) : $urandom_range(7, 20);
    if ($urandom_range(0, 40) == 0) len = 99;
    fb.push_back(CH_START);
    fb.push_back(8'(CH_ZERO + len / 10));
    fb.push_back(8'(CH_ZERO + len % 10));
    fb.push_back(CH_SEP);
    fb.push_back((sel >= 55 && sel < 67) ? 8'($urandom_range(0, 255))
                                         : 8'(tracker.req_type + TYPE_OFFSET));
    fb.push_back((sel >= 67 && sel < 76) ? 8'($urandom_range(0, 255)) : CH_SEP);
    nrest  = len - 6;
    case ($urandom_range(0, 5))
      0:       endpos = -1;
      1:       endpos = $urandom_range(0, nrest - 1);
      default: endpos = nrest - 1;
    endcase
    for (int i = 0; i < nrest; i++) begin
      if (i == endpos) fb.push_back(CH_END);
      else if ($urandom_range(0, 15) == 0) fb.push_back(CH_START);
      else fb.push_back(8'($urandom_range(0, 255)));
    end
    if (sel >= 76 && sel < 86) begin
      case ($urandom_range(0, 2))
        0:       bad = 8'(CH_ZERO - 1);
        1:       bad = 8'(CH_NINE + 1);
        default: bad = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 3))
        0: fb[1] = bad;
        1: fb[2] = bad;
        2: fb[3] = 8'($urandom_range(0, 255));
        default: begin
          fb[1] = CH_ZERO;
          fb[2] = 8'(CH_ZERO + $urandom_range(0, 6));
        end
      endcase
      fb = fb[0:3];
    end else if (sel >= 86 && sel < 92) begin
      fb = fb[0:$urandom_range(0, fb.size() - 2)];
    end else if (sel >= 92) begin
      fb.delete();
      repeat ($urandom_range(1, 4)) fb.push_back(8'($urandom_range(0, 255)));
    end
    foreach (fb[i]) push_byte(fb[i]);
  endtask

  initial begin
    logic [7:0] req_seq[7];
    req_seq = '{CH_REQ_HI, CH_ZERO, 8'h00, 8'(CH_ZERO + 2), 8'hFF, 8'(CH_REQ_HI + 1),
                CH_REQ_HI};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // noise extremes, header failures, shortest good frame, frame without end mark
    push_byte(8'h00);
    push_byte(8'hFF);
    send_text("<1x$");
    send_text("<07#");
    send_text("<06$");
    send_text("<07$9$>");
    send_text("<08$9$<x");

    for (int i = 0; i < 7; i++) begin
      if (i > 0) begin
        let_block_settle();
        write_request_type(req_seq[i]);
      end
      while (tracker.n_bytes < (i + 1) * PhaseBytes) send_random_frame();
    end

    let_block_settle();
    $display("covered %0d bytes in %0d frames over 7 request type settings",
             tracker.n_bytes, tracker.n_frames);
    $display("checked %0d results: payload %0d ok %0d mismatch %0d no end %0d bad header %0d",
             tracker.n_checked, tracker.n_kind[KIND_PAYLOAD], tracker.n_kind[KIND_OK],
             tracker.n_kind[KIND_MISMATCH], tracker.n_kind[KIND_NO_END],
             tracker.n_kind[KIND_BAD_HDR]);
    if (tracker.n_errors == 0 && tracker.awaited.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results still awaited", tracker.awaited.size());
    $display("FAILURE");
    $finish;
  end

endmodule
